// ===== rtl/sit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// shared sizes, codes and types for the sorted insert table
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = DEPTH / GROUP_SIZE;

    // operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                 do_insert;
        logic                 do_remove;
        logic [WORD_BITS-1:0] value;
        logic [IDX_W-1:0]     index;
    } cell_op_t;

endpackage

// ===== rtl/sit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_cell
// one list slot: holds an entry, compares it and shifts with its neighbours
// ----------------------------------------------------------------------------
module sit_cell (
    input  logic                          aclk,
    input  logic [sit_pkg::IDX_W-1:0]     cell_idx,
    input  sit_pkg::cell_op_t             op,
    input  logic [sit_pkg::CNT_W-1:0]     count,
    input  logic [sit_pkg::WORD_BITS-1:0] left_entry,
    input  logic                          left_less,
    input  logic [sit_pkg::WORD_BITS-1:0] right_entry,
    output logic [sit_pkg::WORD_BITS-1:0] entry,
    output logic                          less,
    output logic [sit_pkg::WORD_BITS-1:0] read_word
);
    import sit_pkg::*;

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic                 occupied;

    assign occupied  = {1'b0, cell_idx} < count;
    assign less      = occupied && (entry_reg < op.value);
    assign entry     = entry_reg;
    assign read_word = (cell_idx == op.index) ? entry_reg : '0;

    always_comb begin
        entry_next = entry_reg;
        if (op.do_insert && !less) begin
            // first slot not below the new value takes it, later ones move up
            entry_next = left_less ? op.value : left_entry;
        end else if (op.do_remove && (cell_idx >= op.index)) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sorted_insert_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_table_top
// ascending list of words held in a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request per beat; s_tuser carries the operation
//   (insert, read, remove), s_tdata the value and the index
//   m_ channel: one result per request with read value, status and count
//   cfg channel: writes the capacity; cfg_ready is always high, write only
//   while no request is in flight
// timing
//   the request is registered at the accepting edge; in the next cycle
//   (ST_EXEC) every cell compares and shifts at once and the read word is
//   gathered in groups of eight into the group registers; in ST_FINISH the
//   final gather loads the output register once that register is free
//   one request is worked on at a time, so a new request is accepted only
//   after the previous result has been loaded into the output register
// reset and stall
//   reset empties the list (count zero) and sets capacity to the full depth;
//   entry contents are not cleared
//   a result waits in the output register while m_tready is low; the next
//   request is still accepted and held until the output register frees
// ----------------------------------------------------------------------------
module sorted_insert_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,    // capacity
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // value[31:0], index[37:32], zero fill
    input  logic [1:0]  s_tuser,     // mode[1:0]
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata      // read_value[31:0], status[33:32], count[40:34]
);
    import sit_pkg::*;

    localparam int OUT_BITS = WORD_BITS + 2 + CNT_W;

    state_t state_reg, state_next;

    // registered request
    logic [1:0]           mode_reg;
    logic [WORD_BITS-1:0] value_reg;
    logic [IDX_W-1:0]     index_reg;

    logic [CNT_W-1:0]     capacity_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic                 read_ok_reg, read_ok_next;
    logic [WORD_BITS-1:0] group_reg [GROUPS];
    logic [WORD_BITS-1:0] group_next [GROUPS];

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0]  m_data_reg;
    logic [WORD_BITS-1:0] gathered;

    logic [CNT_W-1:0]     eff_cap;
    logic                 list_full;
    logic                 index_bad;
    logic                 accept;
    logic                 load_out;
    cell_op_t             op;

    logic [WORD_BITS-1:0] entry_w [DEPTH];
    logic                 less_w  [DEPTH];
    logic [WORD_BITS-1:0] rd_w    [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_out  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(48 - OUT_BITS){1'b0}}, m_data_reg};

    // capacity above the depth acts as the depth
    assign eff_cap   = (capacity_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;
    assign list_full = (count_reg >= eff_cap) || (count_reg >= CNT_W'(DEPTH));
    assign index_bad = ({1'b0, index_reg} >= count_reg);

    // broadcast command, live only in the execute cycle
    always_comb begin
        op.do_insert = (state_reg == ST_EXEC) && (mode_reg == MODE_INSERT) && !list_full;
        op.do_remove = (state_reg == ST_EXEC) && (mode_reg == MODE_REMOVE) && !index_bad;
        op.value     = value_reg;
        op.index     = index_reg;
    end

    // the cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_e;
        logic                 left_l;
        logic [WORD_BITS-1:0] right_e;

        if (i == 0) begin : g_first
            // nothing below the first cell, so it takes the value when not below it
            assign left_e = '0;
            assign left_l = 1'b1;
        end else begin : g_mid
            assign left_e = entry_w[i-1];
            assign left_l = less_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = entry_w[i+1];
        end

        sit_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(i)),
            .op          (op),
            .count       (count_reg),
            .left_entry  (left_e),
            .left_less   (left_l),
            .right_entry (right_e),
            .entry       (entry_w[i]),
            .less        (less_w[i]),
            .read_word   (rd_w[i])
        );
    end

    // first gather level: one or-group of eight cells each
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                group_next[g] = group_next[g] | rd_w[g*GROUP_SIZE + k];
            end
        end
    end

    // final gather over the group registers
    always_comb begin
        gathered = '0;
        for (int g = 0; g < GROUPS; g++) begin
            gathered = gathered | group_reg[g];
        end
        if (!read_ok_reg) begin
            gathered = '0;
        end
    end

    // status and count for the execute cycle
    always_comb begin
        status_next  = status_reg;
        read_ok_next = read_ok_reg;
        count_next   = count_reg;
        if (state_reg == ST_EXEC) begin
            status_next  = STATUS_OK;
            read_ok_next = 1'b0;
            case (mode_reg)
                MODE_INSERT: begin
                    if (list_full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (index_bad) begin
                        status_next = STATUS_RANGE;
                    end else begin
                        read_ok_next = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (index_bad) begin
                        status_next = STATUS_RANGE;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    // unused code leaves the list alone
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
            capacity_reg <= CNT_W'(DEPTH);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_tuser;
            value_reg <= s_tdata[WORD_BITS-1:0];
            index_reg <= s_tdata[32 +: IDX_W];
        end
        status_reg  <= status_next;
        read_ok_reg <= read_ok_next;
        if (state_reg == ST_EXEC) begin
            for (int g = 0; g < GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
        if (load_out) begin
            m_data_reg <= {count_reg, status_reg, gathered};
        end
    end

endmodule

// ===== rtl/sit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_checker
// port-level checks on the sorted insert table, bound to the top level
// ----------------------------------------------------------------------------
module sit_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import sit_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // count never above depth and failed requests carry no read word
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40:34] <= 7'(DEPTH))
                     && (m_tdata[33:32] == STATUS_OK || m_tdata[31:0] == '0))
        else $error("bad result fields");

    // a request taken while no result waits does not bring m_tvalid high straight away
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind sorted_insert_table_top sit_checker u_sit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted insert table
// ----------------------------------------------------------------------------
// every accepted request is run through a behavioural copy of the list (sorted
// words, count, capacity) and the expected result is queued; each result from
// the block is compared field by field with the oldest queued one. directed
// tests cover empty, full and out-of-range cases and the capacity extremes;
// the random part fills and drains the list under several capacities and
// idle/stall patterns, including a long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
    import sit_pkg::*;

    // mode 3 has no operation; the block must answer it with the count only
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         MAX_PRINTS  = 50;

    // one result as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  count;
        logic [1:0]  status;
        logic [31:0] read_value;
    } list_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;     // value[31:0], index[37:32], zero fill
    logic [1:0]  s_tuser   = '0;     // mode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;            // read_value[31:0], status[33:32], count[40:34]

    // behavioural copy of the list
    logic [WORD_BITS-1:0] list_words [DEPTH];
    int                   list_count   = 0;
    logic [6:0]           capacity_reg = 7'd64;

    list_result_t expected_results [$];
    int           mismatches     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;
    logic         hold_go        = 1'b0;
    bit           offering       = 1'b0;
    bit           filling        = 1'b1;

    sorted_insert_table_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction: applies one request to the copy of the list
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_request(logic [1:0] mode,
                                                   logic [WORD_BITS-1:0] value,
                                                   logic [IDX_W-1:0] index);
        list_result_t r;
        int           limit;
        int           pos;
        r = '0;
        // a capacity above the depth behaves as the full depth
        limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        case (mode)
            MODE_INSERT: begin
                if (list_count >= limit) begin
                    r.status = STATUS_FULL;
                end else begin
                    // new word goes ahead of any equal older ones
                    pos = 0;
                    while (pos < list_count && list_words[pos] < value)
                        pos++;
                    for (int i = list_count; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = value;
                    list_count++;
                    r.status = STATUS_OK;
                end
            end
            MODE_READ: begin
                if (index >= list_count)
                    r.status = STATUS_RANGE;
                else
                    r.read_value = list_words[index];
            end
            MODE_REMOVE: begin
                if (index >= list_count) begin
                    r.status = STATUS_RANGE;
                end else begin
                    for (int i = index; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
            default: r.status = STATUS_OK;
        endcase
        r.count = list_count[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: ready pattern, long hold-off and checking
    // ------------------------------------------------------------------------

    // hold-off counter, started by a one-cycle pulse on hold_go
    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // values sampled here are those present at the edge
    always @(posedge aclk) begin : check_results
        list_result_t want;
        list_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[40:0];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending (%h)", got));
            end else begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              got.read_value, want.read_value));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              got.count, want.count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offers one request, waits for it to be taken, then maybe idles
    task automatic send_request(input logic [1:0] mode, input logic [31:0] value,
                                input logic [5:0] index);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, index, value};
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_request(mode, value, index));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stops offering and waits until every expected result has come back
    task automatic wait_drained();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // capacity is only written with nothing in flight
    task automatic write_capacity(input logic [6:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        capacity_reg = cap;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(9);
        // small words give plenty of equal entries
        if (r < 3)  return $urandom_range(15);
        if (r == 3) return 32'h0000_0000;
        if (r == 4) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // random request that swings the list between filling and draining
    task automatic send_random_request();
        int         limit;
        int         roll;
        logic [1:0] mode;
        logic [5:0] index;
        limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        if (list_count >= limit && limit > 0)
            filling = 1'b0;
        else if (list_count == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
            mode = (roll < 55) ? MODE_INSERT : (roll < 80) ? MODE_READ :
                   (roll < 96) ? MODE_REMOVE : MODE_UNUSED;
        else
            mode = (roll < 15) ? MODE_INSERT : (roll < 45) ? MODE_READ :
                   (roll < 96) ? MODE_REMOVE : MODE_UNUSED;
        if (list_count > 0 && $urandom_range(9) < 8)
            index = 6'($urandom_range(list_count - 1));
        else
            index = 6'($urandom_range(63));
        send_request(mode, (mode == MODE_INSERT) ? pick_word() : $urandom, index);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty list, word extremes, equal words, every operation, index range
    task automatic test_basic_operations();
        send_request(MODE_READ,   32'h0, 6'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd63);
        send_request(MODE_UNUSED, 32'h0, 6'd0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0000, 6'd63);
        send_request(MODE_INSERT, 32'h0000_0005, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0005, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0000, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd2);
        send_request(MODE_READ,   32'h0, 6'd4);
        send_request(MODE_READ,   32'h0, 6'd5);
        send_request(MODE_READ,   32'hFFFF_FFFF, 6'd63);
        send_request(MODE_REMOVE, 32'h0, 6'd4);
        send_request(MODE_REMOVE, 32'h0, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd0);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 6'd63);
    endtask

    // capacity below the count, capacity zero and capacity one
    task automatic test_capacity_limits();
        write_capacity(7'd2);
        send_request(MODE_INSERT, 32'h1234_5678, 6'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd0);
        send_request(MODE_INSERT, 32'h8000_0000, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0001, 6'd0);
        write_capacity(7'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd1);
        send_request(MODE_INSERT, 32'h0000_0002, 6'd0);
        write_capacity(7'd1);
        send_request(MODE_INSERT, 32'h0000_0003, 6'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0004, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0005, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd0);
    endtask

    // capacity above the depth: the list fills to its full depth and no further
    task automatic test_full_depth();
        write_capacity(7'd127);
        while (list_count < DEPTH)
            send_request(MODE_INSERT, pick_word(), 6'($urandom_range(63)));
        send_request(MODE_INSERT, 32'h0000_0000, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd63);
        send_request(MODE_READ,   32'h0, 6'd0);
        send_request(MODE_REMOVE, 32'h0, 6'd63);
        send_request(MODE_REMOVE, 32'h0, 6'd0);
        send_request(MODE_READ,   32'h0, 6'd62);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_request(MODE_INSERT, 32'h0000_0000, 6'd0);
    endtask

    // receiver holds off long enough for the block to stall its input, then the sender
    // pauses until everything has come back and sends more under random receiver stalls
    task automatic test_backpressure();
        write_capacity(7'd64);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        repeat (40) send_random_request();
        wait_drained();
        recv_stall_pct = 54;
        repeat (20) send_random_request();
    endtask

    // random fill and drain under several capacities and idle and stall patterns
    task automatic test_random_phases();
        logic [6:0] caps  [6] = '{7'd64, 7'd8, 7'd1, 7'd127, 7'd40, 7'd64};
        int         sends [6] = '{0, 54, 0, 25, 0, 54};
        int         stalls[6] = '{0, 0, 54, 25, 0, 0};
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            send_idle_pct  = sends[p];
            recv_stall_pct = stalls[p];
            repeat (340) send_random_request();
        end
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_operations();
        test_capacity_limits();
        test_full_depth();
        test_backpressure();
        test_random_phases();
        wait_drained();
        // wait on to catch any stray result
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
